// ===== src/md86_pkg.sv =====
// ---------------------------------------------------------------------------
// md86_pkg
// Shared types and constants for the 16-bit MOV decoder.
// ---------------------------------------------------------------------------
package md86_pkg;

   // opcode patterns
   localparam logic [5:0] OP_MOV_RM  = 6'b100010;  // 100010dw
   localparam logic [3:0] OP_MOV_IMM = 4'b1011;    // 1011wreg
   localparam logic [2:0] RM_DIRECT  = 3'b110;

   localparam logic [1:0] MOD_NO_DISP = 2'b00;
   localparam logic [1:0] MOD_DISP8   = 2'b01;
   localparam logic [1:0] MOD_DISP16  = 2'b10;
   localparam logic [1:0] MOD_REG     = 2'b11;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      PH_OPCODE  = 3'd0,
      PH_MODRM   = 3'd1,
      PH_DISP_LO = 3'd2,
      PH_DISP_HI = 3'd3,
      PH_DISP8   = 3'd4,
      PH_IMM_LO  = 3'd5,
      PH_IMM_HI  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_REGREG = 3'd0,
      KIND_MEM    = 3'd1,
      KIND_IMM    = 3'd2,
      KIND_BADOP  = 3'd3,
      KIND_DIRECT = 3'd4
   } kind_type;

   // classified instruction handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  opcode;
      logic [7:0]  modrm;
      logic        has_disp;
      logic [15:0] value;     // displacement or immediate
   } cmd_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

// ===== src/x86_16bit_mov_decoder.sv =====
// ---------------------------------------------------------------------------
// x86_16bit_mov_decoder
// 8086 MOV decoder: byte stream in, one decoded record per instruction out.
// ---------------------------------------------------------------------------
// Throughput: one code byte per cycle; req_full only rises when the two-entry
//   instruction queue is full, i.e. when the result side has stopped popping.
// Path: the edge that accepts an instruction's last byte writes the queue; the
//   output register loads from the queue head once free and drives rsp_ directly.
// Reset: synchronous, active high; sequencer awaits an opcode, halt clears,
//   queue and output register empty; requests taken the cycle after reset.
module x86_16bit_mov_decoder
   import md86_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_code_byte,
   // result side
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_kind,
   output logic        rsp_wide,
   output logic        rsp_to_register,
   output logic [2:0]  rsp_dest_reg,
   output logic [2:0]  rsp_source_reg,
   output logic [2:0]  rsp_reg_operand,
   output logic [2:0]  rsp_address_formula,
   output logic        rsp_disp_present,
   output logic [15:0] rsp_displacement,
   output logic [15:0] rsp_immediate
);

   // request accepted this cycle (halted front still swallows bytes)
   logic             byte_accept;
   logic             front_valid;
   cmd_type          front_cmd;
   cmd_type          head_cmd;
   queue_status_type q_status;
   logic             back_take;
   logic             out_valid;

   // Front only stalls on a full queue: every byte yields at most one record,
   // so one free slot is always enough for whatever the byte produces.
   assign req_full    = q_status.full;
   assign byte_accept = req_push && !q_status.full;

   md86_front u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(byte_accept),
      .code_byte (req_code_byte),
      .cmd_valid (front_valid),
      .cmd       (front_cmd)
   );

   // decouples the byte sequencer from the output register
   md86_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_valid),
      .push_cmd(front_cmd),
      .pop     (back_take),
      .head_cmd(head_cmd),
      .status  (q_status)
   );

   // back end refills the output register in the same cycle it is popped, if the queue holds a record
   md86_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_status.valid),
      .cmd            (head_cmd),
      .cmd_take       (back_take),
      .out_valid      (out_valid),
      .out_pop        (rsp_pop),
      .kind           (rsp_kind),
      .wide           (rsp_wide),
      .to_register    (rsp_to_register),
      .dest_reg       (rsp_dest_reg),
      .source_reg     (rsp_source_reg),
      .reg_operand    (rsp_reg_operand),
      .address_formula(rsp_address_formula),
      .disp_present   (rsp_disp_present),
      .displacement   (rsp_displacement),
      .immediate      (rsp_immediate)
   );

   assign rsp_empty = !out_valid;

endmodule

// ===== src/md86_front.sv =====
// ---------------------------------------------------------------------------
// md86_front
// Byte sequencer: collects instruction bytes and classifies each instruction.
// ---------------------------------------------------------------------------
module md86_front
   import md86_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] code_byte,
   output logic       cmd_valid,
   output cmd_type    cmd
);

   phase_type  phase_ff, phase_in;
   logic       halted_ff, halted_in;
   logic [7:0] opcode_ff, opcode_in;
   logic [7:0] modrm_ff, modrm_in;
   logic [7:0] low_ff, low_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         halted_ff <= halted_in;
      end
      opcode_ff <= opcode_in;
      modrm_ff  <= modrm_in;
      low_ff    <= low_in;
   end

   always_comb begin
      phase_in     = phase_ff;
      halted_in    = halted_ff;
      opcode_in    = opcode_ff;
      modrm_in     = modrm_ff;
      low_in       = low_ff;
      cmd_valid    = 1'b0;
      cmd.kind     = KIND_BADOP;
      cmd.opcode   = opcode_ff;
      cmd.modrm    = modrm_ff;
      cmd.has_disp = 1'b0;
      cmd.value    = 16'h0000;

      if (byte_valid && !halted_ff) begin
         case (phase_ff)
            PH_OPCODE: begin
               opcode_in = code_byte;
               if (code_byte[7:2] == OP_MOV_RM) begin
                  phase_in = PH_MODRM;
               end else if (code_byte[7:4] == OP_MOV_IMM) begin
                  phase_in = PH_IMM_LO;
               end else begin
                  cmd_valid = 1'b1;
                  cmd.kind  = KIND_BADOP;
                  halted_in = 1'b1;
               end
            end
            PH_MODRM: begin
               modrm_in  = code_byte;
               cmd.modrm = code_byte;
               case (code_byte[7:6])
                  MOD_REG: begin
                     cmd_valid = 1'b1;
                     cmd.kind  = KIND_REGREG;
                     phase_in  = PH_OPCODE;
                  end
                  MOD_NO_DISP: begin
                     if (code_byte[2:0] == RM_DIRECT) begin
                        phase_in = PH_DISP_LO;
                     end else begin
                        cmd_valid = 1'b1;
                        cmd.kind  = KIND_MEM;
                        phase_in  = PH_OPCODE;
                     end
                  end
                  MOD_DISP8: begin
                     phase_in = PH_DISP8;
                  end
                  default: begin
                     phase_in = PH_DISP_LO;
                  end
               endcase
            end
            PH_DISP8: begin
               cmd_valid    = 1'b1;
               cmd.kind     = KIND_MEM;
               cmd.has_disp = 1'b1;
               cmd.value    = {8'h00, code_byte};
               phase_in     = PH_OPCODE;
            end
            PH_DISP_LO: begin
               low_in   = code_byte;
               phase_in = PH_DISP_HI;
            end
            PH_DISP_HI: begin
               cmd_valid    = 1'b1;
               cmd.has_disp = 1'b1;
               cmd.value    = {code_byte, low_ff};
               phase_in     = PH_OPCODE;
               if (modrm_ff[7:6] == MOD_NO_DISP) begin
                  cmd.kind  = KIND_DIRECT;
                  halted_in = 1'b1;
               end else begin
                  cmd.kind = KIND_MEM;
               end
            end
            PH_IMM_LO: begin
               if (opcode_ff[3]) begin
                  low_in   = code_byte;
                  phase_in = PH_IMM_HI;
               end else begin
                  cmd_valid = 1'b1;
                  cmd.kind  = KIND_IMM;
                  cmd.value = {8'h00, code_byte};
                  phase_in  = PH_OPCODE;
               end
            end
            PH_IMM_HI: begin
               cmd_valid = 1'b1;
               cmd.kind  = KIND_IMM;
               cmd.value = {code_byte, low_ff};
               phase_in  = PH_OPCODE;
            end
            default: begin
               phase_in = PH_OPCODE;
            end
         endcase
      end
   end

   // once halted, nothing more leaves the front
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !cmd_valid)
      else $error("front emitted after halt");

   // an error record always halts the sequencer on the next cycle
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && (cmd.kind == KIND_BADOP || cmd.kind == KIND_DIRECT) |=> halted_ff)
      else $error("error record without halt");

   // a record is only produced for an accepted byte
   a_emit_on_byte: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> byte_valid)
      else $error("record without byte");

endmodule

// ===== src/md86_queue.sv =====
// ---------------------------------------------------------------------------
// md86_queue
// Two-entry queue of classified instructions between front and back.
// ---------------------------------------------------------------------------
module md86_queue
   import md86_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign do_pop       = pop && status.valid;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("push into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || status.full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ===== src/md86_back.sv =====
// ---------------------------------------------------------------------------
// md86_back
// Expands a classified instruction into the result record and holds it in
// the output register.
// ---------------------------------------------------------------------------
module md86_back
   import md86_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_take,
   output logic        out_valid,
   input  logic        out_pop,
   output logic [2:0]  kind,
   output logic        wide,
   output logic        to_register,
   output logic [2:0]  dest_reg,
   output logic [2:0]  source_reg,
   output logic [2:0]  reg_operand,
   output logic [2:0]  address_formula,
   output logic        disp_present,
   output logic [15:0] displacement,
   output logic [15:0] immediate
);

   logic        valid_ff, valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic        wide_ff, wide_in;
   logic        to_reg_ff, to_reg_in;
   logic [2:0]  dest_ff, dest_in;
   logic [2:0]  src_ff, src_in;
   logic [2:0]  regop_ff, regop_in;
   logic [2:0]  formula_ff, formula_in;
   logic        has_disp_ff, has_disp_in;
   logic [15:0] disp_ff, disp_in;
   logic [15:0] imm_ff, imm_in;

   assign cmd_take = cmd_valid && (!valid_ff || out_pop);

   always_comb begin
      valid_in    = valid_ff;
      kind_in     = kind_ff;
      wide_in     = wide_ff;
      to_reg_in   = to_reg_ff;
      dest_in     = dest_ff;
      src_in      = src_ff;
      regop_in    = regop_ff;
      formula_in  = formula_ff;
      has_disp_in = has_disp_ff;
      disp_in     = disp_ff;
      imm_in      = imm_ff;

      if (out_pop) begin
         valid_in = 1'b0;
      end

      if (cmd_take) begin
         valid_in    = 1'b1;
         kind_in     = cmd.kind;
         wide_in     = 1'b0;
         to_reg_in   = 1'b0;
         dest_in     = 3'd0;
         src_in      = 3'd0;
         regop_in    = 3'd0;
         formula_in  = 3'd0;
         has_disp_in = 1'b0;
         disp_in     = 16'h0000;
         imm_in      = 16'h0000;
         case (cmd.kind)
            KIND_REGREG: begin
               wide_in   = cmd.opcode[0];
               to_reg_in = cmd.opcode[1];
               dest_in   = cmd.opcode[1] ? cmd.modrm[5:3] : cmd.modrm[2:0];
               src_in    = cmd.opcode[1] ? cmd.modrm[2:0] : cmd.modrm[5:3];
            end
            KIND_MEM, KIND_DIRECT: begin
               wide_in     = cmd.opcode[0];
               to_reg_in   = cmd.opcode[1];
               regop_in    = cmd.modrm[5:3];
               formula_in  = cmd.modrm[2:0];
               has_disp_in = cmd.has_disp;
               disp_in     = cmd.value;
            end
            KIND_IMM: begin
               wide_in   = cmd.opcode[3];
               to_reg_in = 1'b1;
               dest_in   = cmd.opcode[2:0];
               imm_in    = cmd.value;
            end
            default: begin
               // unsupported opcode: all fields but kind stay zero
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      kind_ff     <= kind_in;
      wide_ff     <= wide_in;
      to_reg_ff   <= to_reg_in;
      dest_ff     <= dest_in;
      src_ff      <= src_in;
      regop_ff    <= regop_in;
      formula_ff  <= formula_in;
      has_disp_ff <= has_disp_in;
      disp_ff     <= disp_in;
      imm_ff      <= imm_in;
   end

   assign out_valid       = valid_ff;
   assign kind            = kind_ff;
   assign wide            = wide_ff;
   assign to_register     = to_reg_ff;
   assign dest_reg        = dest_ff;
   assign source_reg      = src_ff;
   assign reg_operand     = regop_ff;
   assign address_formula = formula_ff;
   assign disp_present    = has_disp_ff;
   assign displacement    = disp_ff;
   assign immediate       = imm_ff;

   // a held result must not be overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_pop |-> !cmd_take)
      else $error("output register overwritten");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> valid_ff)
      else $error("taken record not presented");

   a_record_held: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_pop |=> valid_ff && $stable(kind_ff))
      else $error("held record changed");

endmodule
